FILE: src/hid_keyboard_report_builder_core_macros.svh
// Assertion macros shared by the report builder checker.
`ifndef HID_KEYBOARD_REPORT_BUILDER_CORE_MACROS_SVH
`define HID_KEYBOARD_REPORT_BUILDER_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define HKRB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hkrb check failed: same-cycle rule");

// Next-cycle implication, clocked on clk, off while rst is high.
`define HKRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hkrb check failed: next-cycle rule");

// Same-cycle implication that stays live during reset.
`define HKRB_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("hkrb check failed: reset rule");

`endif

FILE: src/hkrb_pkg.sv
// Types and constants of the HID keyboard report builder.
package hkrb_pkg;

  localparam int KEY_SLOTS_DEF = 6;
  localparam int OUT_KEYS      = 6;

  localparam logic [15:0] PAGE_KEYBOARD = 16'd7;
  localparam logic [15:0] PAGE_CONSUMER = 16'd12;
  localparam logic [7:0]  MOD_FIRST     = 8'hE0;
  localparam logic [7:0]  MOD_LAST      = 8'hE7;

  localparam int IN_TUSER_W  = 2;
  localparam int IN_BITS     = 37;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 11 + 8 * OUT_KEYS + 16;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_TICK   = 2'd2
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [15:0] usage_page;
    logic [15:0] usage_id;
    logic        suspended;
    logic        kbd_ready;
    logic        kbd_accepts;
    logic        cons_ready;
    logic        cons_accepts;
  } item_t;

  typedef struct packed {
    logic                       wakeup_request;
    logic                       kbd_sent;
    logic [7:0]                 mod_mask;
    logic [OUT_KEYS-1:0][7:0]   keys;
    logic                       cons_sent;
    logic [15:0]                cons_usage;
  } result_t;

  // Request to the key slot unit.
  typedef struct packed {
    logic       press;
    logic       release_key;
    logic [7:0] code;
  } slot_op_t;

endpackage

FILE: src/hkrb_in_stage.sv
// Input register stage: captures one request and holds it until processed.
module hkrb_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  hkrb_pkg::item_t in_item,
  input  logic            advance,
  output logic            held_valid,
  output hkrb_pkg::item_t held_item
);
  import hkrb_pkg::*;

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

FILE: src/hkrb_slot_update.sv
// Key slot unit: parallel match, first-free pick, press/release of one code.
module hkrb_slot_update #(
  parameter int KEY_SLOTS = hkrb_pkg::KEY_SLOTS_DEF
) (
  input  hkrb_pkg::slot_op_t         op,
  input  logic [KEY_SLOTS-1:0][7:0]  slots,
  output logic [KEY_SLOTS-1:0][7:0]  slots_next,
  output logic                       changed
);
  import hkrb_pkg::*;

  logic [KEY_SLOTS-1:0] hit;
  logic [KEY_SLOTS-1:0] free;
  logic [KEY_SLOTS-1:0] hit_first;
  logic [KEY_SLOTS-1:0] free_first;
  logic                 press_ok;
  logic                 release_ok;

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      hit[i]  = (slots[i] == op.code);
      free[i] = (slots[i] == 8'd0);
    end
  end

  // lowest set bit isolation
  assign hit_first  = hit & (~hit + KEY_SLOTS'(1));
  assign free_first = free & (~free + KEY_SLOTS'(1));

  assign press_ok   = op.press && (hit == '0) && (free != '0);
  assign release_ok = op.release_key && (hit != '0);
  assign changed    = press_ok || release_ok;

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (press_ok && free_first[i]) begin
        slots_next[i] = op.code;
      end else if (release_ok && hit_first[i]) begin
        slots_next[i] = 8'd0;
      end else begin
        slots_next[i] = slots[i];
      end
    end
  end

endmodule

FILE: src/hid_keyboard_report_builder_core.sv
// Top level of the HID boot keyboard report builder.
// A request taken into the input register moves into the result register when that is free or drains.
// Throughput: one request per cycle unless the result register stalls; the key slot compare
//   and the stale update finish in a single pass between the input and result registers.
// Reset (rst, synchronous): key slots, modifiers, consumer code and stale marks clear,
//   both register stages empty.
module hid_keyboard_report_builder_core #(
  parameter int KEY_SLOTS = hkrb_pkg::KEY_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata, lowest bit up: usage_page[15:0], usage_id[15:0], suspended, kbd_ready,
  //   kbd_accepts, cons_ready, cons_accepts, zero fill
  input  logic [hkrb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: func[1:0] (add, remove, tick)
  input  logic [hkrb_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata, lowest bit up: wakeup_request, kbd_sent, mod_mask[7:0], key_a..key_f
  //   (8 bits each), cons_sent, cons_usage[15:0], zero fill
  output logic [hkrb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import hkrb_pkg::*;

  localparam int OUT_PAD = OUT_TDATA_W - OUT_BITS;

  // ---------------------------------------------------------------------------
  // Input unpacking and the input register
  // ---------------------------------------------------------------------------
  item_t in_item;
  item_t cur;
  logic  cur_valid;
  logic  advance;

  assign in_item.func         = func_t'(s_axis_tuser);
  assign in_item.usage_page   = s_axis_tdata[15:0];
  assign in_item.usage_id     = s_axis_tdata[31:16];
  assign in_item.suspended    = s_axis_tdata[32];
  assign in_item.kbd_ready    = s_axis_tdata[33];
  assign in_item.kbd_accepts  = s_axis_tdata[34];
  assign in_item.cons_ready   = s_axis_tdata[35];
  assign in_item.cons_accepts = s_axis_tdata[36];

  hkrb_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (cur_valid),
    .held_item  (cur)
  );

  // The held request moves on whenever the result register is free or drains now.
  assign advance = cur_valid && (!m_axis_tvalid || m_axis_tready);

  // ---------------------------------------------------------------------------
  // Report state
  // ---------------------------------------------------------------------------
  logic [KEY_SLOTS-1:0][7:0] key_slots;
  logic [KEY_SLOTS-1:0][7:0] key_slots_next;
  logic [7:0]                mod_bits;
  logic [7:0]                mod_bits_next;
  logic [15:0]               consumer_code;
  logic [15:0]               consumer_code_next;
  logic                      kbd_stale;
  logic                      kbd_stale_next;
  logic                      cons_stale;
  logic                      cons_stale_next;

  // ---------------------------------------------------------------------------
  // Decode of the held request
  // ---------------------------------------------------------------------------
  logic [7:0] code;
  logic       is_mod;
  logic [7:0] mod_onehot;
  logic       on_kbd;
  logic       on_cons;
  slot_op_t   slot_op;
  logic       slot_changed;
  logic       wake;
  logic       ksent;
  logic       csent;

  assign code       = cur.usage_id[7:0];
  assign is_mod     = (code >= MOD_FIRST) && (code <= MOD_LAST);
  assign mod_onehot = 8'd1 << code[2:0];
  assign on_kbd     = (cur.usage_page == PAGE_KEYBOARD) && (code != 8'd0);
  assign on_cons    = (cur.usage_page == PAGE_CONSUMER);

  // Keyboard code 0 never reaches the slot unit or the modifier bits.
  assign slot_op.press       = (cur.func == FUNC_ADD) && !cur.suspended && on_kbd && !is_mod;
  assign slot_op.release_key = (cur.func == FUNC_REMOVE) && on_kbd && !is_mod;
  assign slot_op.code        = code;

  hkrb_slot_update #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_slots (
    .op         (slot_op),
    .slots      (key_slots),
    .slots_next (key_slots_next),
    .changed    (slot_changed)
  );

  always_comb begin
    mod_bits_next      = mod_bits;
    consumer_code_next = consumer_code;
    wake               = 1'b0;
    ksent              = 1'b0;
    csent              = 1'b0;
    case (cur.func)
      FUNC_ADD: begin
        // Adding while suspended only asks for a remote wakeup.
        if (cur.suspended) begin
          wake = 1'b1;
        end else if (on_kbd && is_mod) begin
          mod_bits_next = mod_bits | mod_onehot;
        end else if (on_cons) begin
          consumer_code_next = cur.usage_id;
        end
      end
      FUNC_REMOVE: begin
        if (on_kbd && is_mod) begin
          mod_bits_next = mod_bits & ~mod_onehot;
        end else if (on_cons) begin
          consumer_code_next = 16'd0;
        end
      end
      FUNC_TICK: begin
        ksent = kbd_stale && cur.kbd_ready;
        csent = cons_stale && cur.cons_ready;
      end
      default: begin
        // unused code: report state shown, nothing changes
      end
    endcase
  end

  // A change only ever sets a stale mark; only an accepted send clears it.
  always_comb begin
    kbd_stale_next  = kbd_stale || slot_changed || (mod_bits_next != mod_bits);
    cons_stale_next = cons_stale || (consumer_code_next != consumer_code);
    if (ksent && cur.kbd_accepts) begin
      kbd_stale_next = 1'b0;
    end
    if (csent && cur.cons_accepts) begin
      cons_stale_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_slots     <= '0;
      mod_bits      <= 8'd0;
      consumer_code <= 16'd0;
      kbd_stale     <= 1'b0;
      cons_stale    <= 1'b0;
    end else if (advance) begin
      key_slots     <= key_slots_next;
      mod_bits      <= mod_bits_next;
      consumer_code <= consumer_code_next;
      kbd_stale     <= kbd_stale_next;
      cons_stale    <= cons_stale_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  result_t res_next;
  result_t res;

  // Report fields past the configured slot count read as zero.
  generate
    for (genvar j = 0; j < OUT_KEYS; j++) begin : g_out_key
      if (j < KEY_SLOTS) begin : g_live
        assign res_next.keys[j] = key_slots_next[j];
      end else begin : g_zero
        assign res_next.keys[j] = 8'd0;
      end
    end
  endgenerate

  assign res_next.wakeup_request = wake;
  assign res_next.kbd_sent       = ksent;
  assign res_next.mod_mask       = mod_bits_next;
  assign res_next.cons_sent      = csent;
  assign res_next.cons_usage     = consumer_code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_axis_tdata = {{OUT_PAD{1'b0}}, res.cons_usage, res.cons_sent, res.keys,
                         res.mod_mask, res.kbd_sent, res.wakeup_request};

endmodule

FILE: src/hkrb_checker.sv
// Port-level checker for the report builder, bound to the top level.
`include "hid_keyboard_report_builder_core_macros.svh"

module hkrb_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [hkrb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import hkrb_pkg::*;

  // a stalled result holds
  `HKRB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // a wakeup comes only from an add, a send only from a tick
  `HKRB_ASSERT_NOW(a_wake_excl, m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[1] && !m_axis_tdata[58])

  // both stages come out of reset empty
  `HKRB_ASSERT_ALWAYS(a_reset_empty, rst ##1 1'b1, !m_axis_tvalid && s_axis_tready)

  // no request for a cycle empties the input stage; with no result then, none can follow
  `HKRB_ASSERT_NEXT(a_no_phantom, (!m_axis_tvalid && !s_axis_tvalid) ##1 (!m_axis_tvalid), !m_axis_tvalid)

endmodule

bind hid_keyboard_report_builder_core hkrb_checker u_hkrb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: bench/tb_top.sv
// Self-checking bench for the HID keyboard report builder core.
`timescale 1ns / 1ps

module tb_top;
  import hkrb_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         HOLD_CYCLES = 200;
  // Output tdata bit positions, lowest up.
  localparam int KEY_LSB  = 10;
  localparam int CS_BIT   = KEY_LSB + 8 * OUT_KEYS;
  localparam int CU_LSB   = CS_BIT + 1;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] page;
    logic [15:0] id;
    logic        susp;
    logic        kbd_ready;
    logic        kbd_accepts;
    logic        cons_ready;
    logic        cons_accepts;
  } key_event_t;

  logic clk;
  logic rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic [IN_TUSER_W-1:0]   s_axis_tuser  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;

  // Mirror of the report state.
  logic [7:0]  slot_mem [KEY_SLOTS_DEF];
  logic [7:0]  mod_state  = 8'h00;
  logic [15:0] cons_state = 16'h0000;
  logic        kbd_stale  = 1'b0;
  logic        cons_stale = 1'b0;

  result_t reports_due [$];
  int      fail_count    = 0;
  int      cycle_count   = 0;
  int      src_idle_pct  = 0;
  int      snk_stall_pct = 0;
  logic    hold_rx       = 1'b0;

  hid_keyboard_report_builder_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < KEY_SLOTS_DEF; i++) slot_mem[i] = 8'h00;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: random stalls, plus a forced hold while hold_rx is up.
  always @(posedge clk) begin
    m_axis_tready <= !hold_rx && ($urandom_range(99) >= snk_stall_pct);
  end

  // Applies one request to the mirror and returns the report it should produce.
  function automatic result_t update_report(key_event_t ev);
    result_t    rep;
    logic [7:0] code;
    logic [7:0] nxt;
    logic       hit;
    rep  = '0;
    code = ev.id[7:0];
    case (ev.op)
      FUNC_ADD: begin
        if (ev.susp) begin
          rep.wakeup_request = 1'b1;
        end else if (ev.page == PAGE_KEYBOARD && code != 8'h00) begin
          if (code >= MOD_FIRST && code <= MOD_LAST) begin
            nxt = mod_state | (8'd1 << code[2:0]);
            if (nxt != mod_state) begin
              mod_state = nxt;
              kbd_stale = 1'b1;
            end
          end else begin
            hit = 1'b0;
            for (int i = 0; i < KEY_SLOTS_DEF; i++)
              if (slot_mem[i] == code) hit = 1'b1;
            // first free slot; a full report drops the key
            for (int i = 0; i < KEY_SLOTS_DEF; i++)
              if (!hit && slot_mem[i] == 8'h00) begin
                slot_mem[i] = code;
                kbd_stale   = 1'b1;
                hit         = 1'b1;
              end
          end
        end else if (ev.page == PAGE_CONSUMER && cons_state != ev.id) begin
          cons_state = ev.id;
          cons_stale = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (ev.page == PAGE_KEYBOARD && code != 8'h00) begin
          if (code >= MOD_FIRST && code <= MOD_LAST) begin
            nxt = mod_state & ~(8'd1 << code[2:0]);
            if (nxt != mod_state) begin
              mod_state = nxt;
              kbd_stale = 1'b1;
            end
          end else begin
            hit = 1'b0;
            for (int i = 0; i < KEY_SLOTS_DEF; i++)
              if (!hit && slot_mem[i] == code) begin
                slot_mem[i] = 8'h00;
                kbd_stale   = 1'b1;
                hit         = 1'b1;
              end
          end
        end else if (ev.page == PAGE_CONSUMER && cons_state != 16'h0000) begin
          cons_state = 16'h0000;
          cons_stale = 1'b1;
        end
      end
      FUNC_TICK: begin
        // refused offers keep the mark for the next tick
        if (kbd_stale && ev.kbd_ready) begin
          rep.kbd_sent = 1'b1;
          if (ev.kbd_accepts) kbd_stale = 1'b0;
        end
        if (cons_stale && ev.cons_ready) begin
          rep.cons_sent = 1'b1;
          if (ev.cons_accepts) cons_stale = 1'b0;
        end
      end
      default: ;
    endcase
    rep.mod_mask = mod_state;
    for (int j = 0; j < OUT_KEYS; j++)
      rep.keys[j] = (j < KEY_SLOTS_DEF) ? slot_mem[j] : 8'h00;
    rep.cons_usage = cons_state;
    return rep;
  endfunction

  function automatic key_event_t make_event(logic [1:0] op, logic [15:0] page,
                                            logic [15:0] id, logic susp,
                                            logic [3:0] rdy);
    key_event_t ev;
    ev.op   = op;
    ev.page = page;
    ev.id   = id;
    ev.susp = susp;
    {ev.kbd_ready, ev.kbd_accepts, ev.cons_ready, ev.cons_accepts} = rdy;
    return ev;
  endfunction

  // Mostly well-formed key and consumer traffic over a small code pool, so that
  // slots fill, duplicates and releases hit; the rest is noise.
  function automatic key_event_t random_event();
    key_event_t ev;
    int         r;
    int         pick;
    ev.op           = FUNC_TICK;
    ev.page         = 16'($urandom);
    ev.id           = 16'($urandom);
    ev.susp         = ($urandom_range(99) < 8);
    ev.kbd_ready    = ($urandom_range(3) != 0);
    ev.kbd_accepts  = ($urandom_range(3) != 0);
    ev.cons_ready   = ($urandom_range(3) != 0);
    ev.cons_accepts = ($urandom_range(3) != 0);
    r = $urandom_range(99);
    if (r < 45) begin
      ev.op   = ($urandom_range(99) < 55) ? FUNC_ADD : FUNC_REMOVE;
      ev.page = PAGE_KEYBOARD;
      pick    = $urandom_range(99);
      if (pick < 65)      ev.id = 16'h0004 + 16'($urandom_range(7));
      else if (pick < 82) ev.id = {8'h00, MOD_FIRST + 8'($urandom_range(7))};
      else if (pick < 88) ev.id = 16'h0000;
      else                ev.id = {8'h00, 8'($urandom)};
      if ($urandom_range(4) == 0) ev.id[15:8] = 8'($urandom);
    end else if (r < 58) begin
      ev.op   = ($urandom_range(99) < 55) ? FUNC_ADD : FUNC_REMOVE;
      ev.page = PAGE_CONSUMER;
      pick    = $urandom_range(99);
      if (pick < 40)      ev.id = 16'h00E9;
      else if (pick < 65) ev.id = 16'h00EA;
      else if (pick < 80) ev.id = 16'h0000;
    end else if (r < 88) begin
      ev.op = FUNC_TICK;
    end else if (r < 95) begin
      ev.op = 2'($urandom_range(3));
    end else begin
      ev.op = FUNC_UNUSED;
    end
    return ev;
  endfunction

  // Offers one request, waits for the handshake, then records its report.
  task automatic send_event(key_event_t ev);
    logic [IN_TDATA_W-1:0] bus;
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    bus      = '0;
    bus[15:0]  = ev.page;
    bus[31:16] = ev.id;
    bus[32]    = ev.susp;
    bus[33]    = ev.kbd_ready;
    bus[34]    = ev.kbd_accepts;
    bus[35]    = ev.cons_ready;
    bus[36]    = ev.cons_accepts;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bus;
    s_axis_tuser  <= ev.op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    reports_due.push_back(update_report(ev));
  endtask

  task automatic wait_drained();
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : report_check
    result_t                want;
    logic [OUT_TDATA_W-1:0] got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (reports_due.size() == 0) begin
        $error("report with no request outstanding: %h", got);
        fail_count++;
      end else begin
        want = reports_due.pop_front();
        check_field("wakeup_request", 16'(want.wakeup_request), 16'(got[0]));
        check_field("kbd_sent", 16'(want.kbd_sent), 16'(got[1]));
        check_field("mod_mask", 16'(want.mod_mask), 16'(got[9:2]));
        for (int j = 0; j < OUT_KEYS; j++)
          check_field($sformatf("key_%c", 8'h61 + j), 16'(want.keys[j]),
                      16'(got[KEY_LSB + 8 * j +: 8]));
        check_field("cons_sent", 16'(want.cons_sent), 16'(got[CS_BIT]));
        check_field("cons_usage", want.cons_usage, got[CU_LSB +: 16]);
      end
    end
  end

  // Modifier set at both ends of E0..E7, clear of E0, then a plain tick.
  task automatic test_modifiers();
    send_event(make_event(FUNC_ADD, PAGE_KEYBOARD, 16'h00E0, 1'b0, 4'b1111));
    send_event(make_event(FUNC_ADD, PAGE_KEYBOARD, 16'h00E7, 1'b0, 4'b1111));
    send_event(make_event(FUNC_REMOVE, PAGE_KEYBOARD, 16'h00E0, 1'b0, 4'b1111));
    send_event(make_event(FUNC_TICK, 16'h0000, 16'h0000, 1'b0, 4'b1111));
  endtask

  // Code zero, five keys, duplicate with high byte set, a sixth fills the slots, drop when full, release.
  task automatic test_key_slots();
    send_event(make_event(FUNC_ADD, PAGE_KEYBOARD, 16'h0000, 1'b0, 4'b1111));
    for (int k = 4; k <= 8; k++)
      send_event(make_event(FUNC_ADD, PAGE_KEYBOARD, 16'(k), 1'b0, 4'b1111));
    send_event(make_event(FUNC_ADD, PAGE_KEYBOARD, 16'hFF04, 1'b0, 4'b1111));
    send_event(make_event(FUNC_ADD, PAGE_KEYBOARD, 16'h00FF, 1'b0, 4'b1111));
    send_event(make_event(FUNC_ADD, PAGE_KEYBOARD, 16'h000A, 1'b0, 4'b1111));
    send_event(make_event(FUNC_REMOVE, PAGE_KEYBOARD, 16'h0006, 1'b0, 4'b1111));
    send_event(make_event(FUNC_REMOVE, PAGE_KEYBOARD, 16'h0000, 1'b0, 4'b1111));
  endtask

  // Consumer code at its top value, unchanged add, refused offer, accepted, cleared.
  task automatic test_consumer();
    send_event(make_event(FUNC_ADD, PAGE_CONSUMER, 16'hFFFF, 1'b0, 4'b1111));
    send_event(make_event(FUNC_ADD, PAGE_CONSUMER, 16'hFFFF, 1'b0, 4'b1111));
    send_event(make_event(FUNC_TICK, 16'h0000, 16'h0000, 1'b0, 4'b0010));
    send_event(make_event(FUNC_TICK, 16'hFFFF, 16'hFFFF, 1'b1, 4'b1111));
    send_event(make_event(FUNC_REMOVE, PAGE_CONSUMER, 16'h1234, 1'b0, 4'b0000));
  endtask

  // Suspended add, suspended remove, unused function code, foreign page.
  task automatic test_suspend_and_noise();
    send_event(make_event(FUNC_ADD, PAGE_KEYBOARD, 16'h000B, 1'b1, 4'b1111));
    send_event(make_event(FUNC_REMOVE, PAGE_KEYBOARD, 16'h0004, 1'b1, 4'b1111));
    send_event(make_event(FUNC_UNUSED, PAGE_KEYBOARD, 16'h00E1, 1'b0, 4'b1111));
    send_event(make_event(FUNC_ADD, 16'hFFFF, 16'hFFFF, 1'b0, 4'b0000));
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    repeat (count) send_event(random_event());
  endtask

  // Receiver held off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    fork
      begin
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
      end
      repeat (40) send_event(random_event());
    join
  endtask

  // Sender stops until every report is back, then resumes.
  task automatic test_drain_pause();
    src_idle_pct  = 0;
    snk_stall_pct = 29;
    repeat (20) send_event(random_event());
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (20) send_event(random_event());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_modifiers();
    test_key_slots();
    test_consumer();
    test_suspend_and_noise();
    test_random_traffic(200, 0, 0);
    test_random_traffic(200, 49, 0);
    test_random_traffic(200, 0, 49);
    test_random_traffic(200, 29, 29);
    test_backpressure();
    test_drain_pause();
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
